// ===== rtl/akf_pkg.sv =====
// shared types, constants and operation table of the altitude kalman filter
`default_nettype none
package akf_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CntW         = 7;
  localparam int unsigned PcW          = 5;
  localparam int unsigned MulDigitW    = 16;
  localparam int unsigned MulDigits    = 4;
  localparam int unsigned DigitIdxW    = $clog2(MulDigits);
  localparam int unsigned DivSteps     = 128;
  localparam int unsigned RootSteps    = 32;

  localparam logic [PcW-1:0] PcPredFirst = 5'd0;
  localparam logic [PcW-1:0] PcRootAfter = 5'd2;
  localparam logic [PcW-1:0] PcPredLast  = 5'd14;
  localparam logic [PcW-1:0] PcMeasFirst = 5'd15;
  localparam logic [PcW-1:0] PcMeasLast  = 5'd20;

  localparam logic [30:0] GravityRst     = 31'd642253;
  localparam logic [30:0] AccelVarRst    = 31'd132540;
  localparam logic [30:0] SonarVarRst    = 31'd1678;
  localparam logic [30:0] SonarOffsetRst = 31'd2556;
  localparam logic [63:0] CovDiagRst     = 64'd41943;
  localparam logic [63:0] TermLim        = 64'd1 << 60;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRAVITY      = 3'd0,
    REG_ACCEL_VAR    = 3'd1,
    REG_SONAR_VAR    = 3'd2,
    REG_SONAR_OFFSET = 3'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_RAW = 2'd0,
    MODE_SH  = 2'd1,
    MODE_DIV = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    A_MX, A_MY, A_MZ, A_DT, A_DT2, A_V, A_ACC, A_PSUM, A_P11, A_Q, A_P00, A_P10
  } a_sel_e;

  typedef enum logic [3:0] {
    B_MX, B_MY, B_MZ, B_DT, B_DT2, B_DT3, B_DT4, B_Y, B_P00, B_P01
  } b_sel_e;

  typedef enum logic [3:0] {
    D_SSUM, D_DT2, D_DT3, D_DT4, D_H, D_V, D_P00, D_P01, D_P01_P10, D_P10, D_P11
  } dest_e;

  typedef struct packed {
    a_sel_e     a_sel;
    b_sel_e     b_sel;
    mode_e      mode;
    logic [6:0] sh;
    dest_e      dest;
    logic       sub;
  } op_t;

  typedef struct packed {
    logic                 load;
    logic                 skip;
    logic                 init;
    logic                 mul_step;
    logic                 mul_first;
    logic [DigitIdxW-1:0] digit;
    logic                 round;
    logic                 div_prep;
    logic                 div_step;
    logic                 fin;
    logic                 root_init;
    logic                 root_step;
    logic                 acc_set;
    logic                 commit;
    logic                 out_load;
    op_t                  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_meas;
    logic s_nonpos;
  } dp_status_t;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        dt;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic [30:0]        range_m;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic signed [31:0] velocity;
    logic signed [31:0] cov_hh;
    logic signed [31:0] cov_hv;
    logic signed [31:0] cov_vh;
    logic signed [31:0] cov_vv;
    logic               saturated;
  } out_item_t;

  function automatic op_t op_rom(input logic [PcW-1:0] pc);
    op_t op;
    unique case (pc)
      5'd0:    op = '{A_MX,   B_MX,  MODE_RAW, 7'd0,  D_SSUM,    1'b0};
      5'd1:    op = '{A_MY,   B_MY,  MODE_RAW, 7'd0,  D_SSUM,    1'b0};
      5'd2:    op = '{A_MZ,   B_MZ,  MODE_RAW, 7'd0,  D_SSUM,    1'b0};
      5'd3:    op = '{A_DT,   B_DT,  MODE_RAW, 7'd0,  D_DT2,     1'b0};
      5'd4:    op = '{A_DT2,  B_DT,  MODE_RAW, 7'd0,  D_DT3,     1'b0};
      5'd5:    op = '{A_DT2,  B_DT2, MODE_RAW, 7'd0,  D_DT4,     1'b0};
      5'd6:    op = '{A_V,    B_DT,  MODE_SH,  7'd16, D_H,       1'b0};
      5'd7:    op = '{A_ACC,  B_DT2, MODE_SH,  7'd33, D_H,       1'b0};
      5'd8:    op = '{A_ACC,  B_DT,  MODE_SH,  7'd16, D_V,       1'b0};
      5'd9:    op = '{A_PSUM, B_DT,  MODE_SH,  7'd16, D_P00,     1'b0};
      5'd10:   op = '{A_P11,  B_DT2, MODE_SH,  7'd32, D_P00,     1'b0};
      5'd11:   op = '{A_Q,    B_DT4, MODE_SH,  7'd66, D_P00,     1'b0};
      5'd12:   op = '{A_P11,  B_DT,  MODE_SH,  7'd16, D_P01_P10, 1'b0};
      5'd13:   op = '{A_Q,    B_DT3, MODE_SH,  7'd49, D_P01_P10, 1'b0};
      5'd14:   op = '{A_Q,    B_DT2, MODE_SH,  7'd32, D_P11,     1'b0};
      5'd15:   op = '{A_P00,  B_Y,   MODE_DIV, 7'd0,  D_H,       1'b0};
      5'd16:   op = '{A_P10,  B_Y,   MODE_DIV, 7'd0,  D_V,       1'b0};
      5'd17:   op = '{A_P00,  B_P00, MODE_DIV, 7'd0,  D_P00,     1'b1};
      5'd18:   op = '{A_P00,  B_P01, MODE_DIV, 7'd0,  D_P01,     1'b1};
      5'd19:   op = '{A_P10,  B_P00, MODE_DIV, 7'd0,  D_P10,     1'b1};
      5'd20:   op = '{A_P10,  B_P01, MODE_DIV, 7'd0,  D_P11,     1'b1};
      default: op = '{A_MX,   B_MX,  MODE_RAW, 7'd0,  D_SSUM,    1'b0};
    endcase
    return op;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    logic [63:0] m;
    m = a[63] ? 64'(-a) : 64'(a);
    return m;
  endfunction

  // {clip, value} of a word saturated to 32 bits signed
  function automatic logic [32:0] sat32(input logic signed [63:0] x);
    logic [32:0] r;
    if (x > 64'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/altitude_kalman_filter_2state.sv =====
// top level of the two-state altitude kalman filter
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i (in_item_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one transaction at a time; a predict runs on the shared 64x16 multiplier and the 32-step
// root, a measure on the same multiplier and the 128-step restoring divider (one quotient
// bit per cycle)
// reset loads the default configuration, zero state and diagonal covariance
// the next transaction is taken while a result is still held on the output;
// a new result waits in the controller until the output register is free
`default_nettype none
module altitude_kalman_filter_2state #(
  parameter int unsigned DataWidth = akf_pkg::DataWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  akf_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output akf_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [akf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);
  import akf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  akf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  akf_dp #(
    .DataWidth (DataWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule
`default_nettype wire

// ===== rtl/akf_ctrl.sv =====
// sequencing state machine of the altitude kalman filter
`default_nettype none
module akf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  akf_pkg::dp_status_t    status_i,
  output akf_pkg::ctrl_cmd_t     cmd_o
);
  import akf_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_START  = 12'b0000_0000_0010,
    S_MUL    = 12'b0000_0000_0100,
    S_ROUND  = 12'b0000_0000_1000,
    S_DPREP  = 12'b0000_0001_0000,
    S_DIV    = 12'b0000_0010_0000,
    S_FIN    = 12'b0000_0100_0000,
    S_ROOTI  = 12'b0000_1000_0000,
    S_ROOT   = 12'b0001_0000_0000,
    S_ACC    = 12'b0010_0000_0000,
    S_COMMIT = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

  state_e         state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PcW-1:0]  pc_q, pc_d;
  logic            out_valid_q, out_valid_d;
  op_t             op;

  assign op          = op_rom(pc_q);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    pc_d          = pc_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o         = '0;
    cmd_o.op      = op;
    cmd_o.digit   = cnt_q[DigitIdxW-1:0];
    cmd_o.mul_first = (cnt_q == CntW'(MulDigits - 1));
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (status_i.is_meas && status_i.s_nonpos) begin
          cmd_o.skip = 1'b1;
          state_d    = S_DONE;
        end else begin
          cmd_o.init = 1'b1;
          pc_d       = status_i.is_meas ? PcMeasFirst : PcPredFirst;
          cnt_d      = CntW'(MulDigits - 1);
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == '0) begin
          unique case (op.mode)
            MODE_SH:  state_d = S_ROUND;
            MODE_DIV: state_d = S_DPREP;
            default:  state_d = S_FIN;
          endcase
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = S_FIN;
      end
      S_DPREP: begin
        cmd_o.div_prep = 1'b1;
        cnt_d          = CntW'(DivSteps - 1);
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        priority if (!status_i.is_meas && pc_q == PcRootAfter) begin
          state_d = S_ROOTI;
        end else if (pc_q == PcPredLast || pc_q == PcMeasLast) begin
          state_d = S_COMMIT;
        end else begin
          pc_d    = pc_q + 1'b1;
          cnt_d   = CntW'(MulDigits - 1);
          state_d = S_MUL;
        end
      end
      S_ROOTI: begin
        cmd_o.root_init = 1'b1;
        cnt_d           = CntW'(RootSteps - 1);
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_ACC;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_ACC: begin
        cmd_o.acc_set = 1'b1;
        pc_d          = pc_q + 1'b1;
        cnt_d         = CntW'(MulDigits - 1);
        state_d       = S_MUL;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/akf_dp.sv =====
// datapath: state, configuration, shared multiplier, divider and root
`default_nettype none
module akf_dp #(
  parameter int unsigned DataWidth = akf_pkg::DataWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  akf_pkg::ctrl_cmd_t   cmd_i,
  output akf_pkg::dp_status_t  status_o,
  input  akf_pkg::in_item_t    in_data_i,
  output akf_pkg::out_item_t   out_data_o,
  input  logic                 cfg_valid_i,
  input  logic [akf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import akf_pkg::*;

  localparam logic signed [63:0] SatHi = (64'sd1 <<< (DataWidth - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;

  function automatic logic [DataWidth:0] sat_w(input logic signed [63:0] x);
    logic [DataWidth:0] r;
    if (x > SatHi) begin
      r = {1'b1, SatHi[DataWidth-1:0]};
    end else if (x < SatLo) begin
      r = {1'b1, SatLo[DataWidth-1:0]};
    end else begin
      r = {1'b0, x[DataWidth-1:0]};
    end
    return r;
  endfunction

  op_t op;
  assign op = cmd_i.op;

  logic [30:0] grav_q, avar_q, svar_q, soff_q;
  logic signed [DataWidth-1:0] h_q, v_q, p00_q, p01_q, p10_q, p11_q;
  logic clip_q;

  in_item_t item_q;
  logic signed [63:0] nh_q, nv_q, n00_q, n01_q, n10_q, n11_q, acc_q;
  logic [63:0]  ssum_q, dt4_q, rem_q, rn_q, rres_q, rbit_q;
  logic [31:0]  dt2_q;
  logic [47:0]  dt3_q;
  logic [127:0] prod_q;
  out_item_t    out_q;

  logic signed [63:0] h_x, v_x, p00_x, p01_x, p10_x, p11_x, s_x, y_x;
  assign h_x   = 64'(h_q);
  assign v_x   = 64'(v_q);
  assign p00_x = 64'(p00_q);
  assign p01_x = 64'(p01_q);
  assign p10_x = 64'(p10_q);
  assign p11_x = 64'(p11_q);
  assign s_x   = p00_x + $signed({33'd0, svar_q});
  assign y_x   = $signed({33'd0, item_q.range_m}) - $signed({33'd0, soff_q}) - h_x;

  assign status_o.is_meas  = item_q.cmd;
  assign status_o.s_nonpos = (s_x <= 64'sd0);

  // operand selection
  logic signed [63:0] a_val, b_val;
  logic [63:0] a_mag, b_mag;
  logic        neg, b_neg;

  always_comb begin
    unique case (op.a_sel)
      A_MX:    a_val = 64'(item_q.accel_x);
      A_MY:    a_val = 64'(item_q.accel_y);
      A_MZ:    a_val = 64'(item_q.accel_z);
      A_DT:    a_val = $signed({48'd0, item_q.dt});
      A_DT2:   a_val = $signed({32'd0, dt2_q});
      A_V:     a_val = v_x;
      A_ACC:   a_val = acc_q;
      A_PSUM:  a_val = p01_x + p10_x;
      A_P11:   a_val = p11_x;
      A_Q:     a_val = $signed({33'd0, avar_q});
      A_P00:   a_val = p00_x;
      A_P10:   a_val = p10_x;
      default: a_val = '0;
    endcase
    unique case (op.b_sel)
      B_MX:    b_val = $signed(mag64(64'(item_q.accel_x)));
      B_MY:    b_val = $signed(mag64(64'(item_q.accel_y)));
      B_MZ:    b_val = $signed(mag64(64'(item_q.accel_z)));
      B_DT:    b_val = $signed({48'd0, item_q.dt});
      B_DT2:   b_val = $signed({32'd0, dt2_q});
      B_DT3:   b_val = $signed({16'd0, dt3_q});
      B_DT4:   b_val = $signed(dt4_q);
      B_Y:     b_val = y_x;
      B_P00:   b_val = p00_x;
      B_P01:   b_val = p01_x;
      default: b_val = '0;
    endcase
  end

  assign a_mag = mag64(a_val);
  assign b_neg = (op.mode == MODE_DIV) && b_val[63];
  assign b_mag = b_neg ? 64'(-b_val) : 64'(b_val);
  assign neg   = ((op.mode != MODE_RAW) && a_val[63]) ^ b_neg;

  // one 64x16 partial product per cycle, top digit first
  logic [MulDigitW-1:0] digit;
  logic [79:0]          pp;
  assign digit = b_mag[cmd_i.digit * MulDigitW +: MulDigitW];
  assign pp    = a_mag * digit;

  logic [127:0] rnd_sum;
  assign rnd_sum = prod_q + (128'd1 << (op.sh - 7'd1));

  logic [64:0] rem_s, rem_diff;
  logic        rem_ge;
  assign rem_s    = {rem_q, prod_q[127]};
  assign rem_diff = rem_s - {1'b0, s_x};
  assign rem_ge   = (rem_s >= {1'b0, s_x});

  logic        over;
  logic [63:0] term_mag;
  logic signed [63:0] term_s;
  assign over     = (|prod_q[127:64]) || (prod_q[63:0] > TermLim);
  assign term_mag = over ? TermLim : prod_q[63:0];
  assign term_s   = (neg ^ op.sub) ? -$signed(term_mag) : $signed(term_mag);

  logic [63:0] rsum;
  assign rsum = rres_q + rbit_q;

  logic [DataWidth:0] sat_h, sat_v, sat_00, sat_01, sat_10, sat_11;
  assign sat_h  = sat_w(nh_q);
  assign sat_v  = sat_w(nv_q);
  assign sat_00 = sat_w(n00_q);
  assign sat_01 = sat_w(n01_q);
  assign sat_10 = sat_w(n10_q);
  assign sat_11 = sat_w(n11_q);

  logic [32:0] o_h, o_v, o_00, o_01, o_10, o_11;
  assign o_h  = sat32(h_x);
  assign o_v  = sat32(v_x);
  assign o_00 = sat32(p00_x);
  assign o_01 = sat32(p01_x);
  assign o_10 = sat32(p10_x);
  assign o_11 = sat32(p11_x);

  // configuration, filter state and clip flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= GravityRst;
      avar_q <= AccelVarRst;
      svar_q <= SonarVarRst;
      soff_q <= SonarOffsetRst;
      h_q    <= '0;
      v_q    <= '0;
      p00_q  <= CovDiagRst[DataWidth-1:0];
      p01_q  <= '0;
      p10_q  <= '0;
      p11_q  <= CovDiagRst[DataWidth-1:0];
      clip_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_GRAVITY:      grav_q <= cfg_data_i[30:0];
          REG_ACCEL_VAR:    avar_q <= cfg_data_i[30:0];
          REG_SONAR_VAR:    svar_q <= cfg_data_i[30:0];
          REG_SONAR_OFFSET: soff_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        clip_q <= 1'b0;
      end
      if (cmd_i.skip) begin
        clip_q <= 1'b1;
      end
      if (cmd_i.fin && op.mode != MODE_RAW && over) begin
        clip_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        h_q   <= sat_h[DataWidth-1:0];
        v_q   <= sat_v[DataWidth-1:0];
        p00_q <= sat_00[DataWidth-1:0];
        p01_q <= sat_01[DataWidth-1:0];
        p10_q <= sat_10[DataWidth-1:0];
        p11_q <= sat_11[DataWidth-1:0];
        if (sat_h[DataWidth] || sat_v[DataWidth] || sat_00[DataWidth] ||
            sat_01[DataWidth] || sat_10[DataWidth] || sat_11[DataWidth]) begin
          clip_q <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.init) begin
      nh_q   <= h_x;
      nv_q   <= v_x;
      n00_q  <= p00_x;
      n01_q  <= p01_x;
      n10_q  <= p10_x;
      n11_q  <= p11_x;
      ssum_q <= '0;
    end
    if (cmd_i.mul_step) begin
      prod_q <= cmd_i.mul_first ? 128'(pp) : (prod_q << MulDigitW) + 128'(pp);
    end
    if (cmd_i.round) begin
      prod_q <= rnd_sum >> op.sh;
    end
    if (cmd_i.div_prep) begin
      prod_q <= prod_q + 128'(s_x >>> 1);
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? rem_diff[63:0] : rem_s[63:0];
      prod_q <= {prod_q[126:0], rem_ge};
    end
    if (cmd_i.fin) begin
      if (op.mode == MODE_RAW) begin
        unique case (op.dest)
          D_SSUM:  ssum_q <= ssum_q + prod_q[63:0];
          D_DT2:   dt2_q  <= prod_q[31:0];
          D_DT3:   dt3_q  <= prod_q[47:0];
          D_DT4:   dt4_q  <= prod_q[63:0];
          default: ;
        endcase
      end else begin
        unique case (op.dest)
          D_H:   nh_q  <= nh_q + term_s;
          D_V:   nv_q  <= nv_q + term_s;
          D_P00: n00_q <= n00_q + term_s;
          D_P01: n01_q <= n01_q + term_s;
          D_P01_P10: begin
            n01_q <= n01_q + term_s;
            n10_q <= n10_q + term_s;
          end
          D_P10:   n10_q <= n10_q + term_s;
          D_P11:   n11_q <= n11_q + term_s;
          default: ;
        endcase
      end
    end
    if (cmd_i.root_init) begin
      rn_q   <= ssum_q;
      rres_q <= '0;
      rbit_q <= 64'd1 << 62;
    end
    if (cmd_i.root_step) begin
      if (rn_q >= rsum) begin
        rn_q   <= rn_q - rsum;
        rres_q <= (rres_q >> 1) + rbit_q;
      end else begin
        rres_q <= rres_q >> 1;
      end
      rbit_q <= rbit_q >> 2;
    end
    if (cmd_i.acc_set) begin
      acc_q <= $signed(rres_q) - $signed({33'd0, grav_q});
    end
    if (cmd_i.out_load) begin
      out_q.height    <= o_h[31:0];
      out_q.velocity  <= o_v[31:0];
      out_q.cov_hh    <= o_00[31:0];
      out_q.cov_hv    <= o_01[31:0];
      out_q.cov_vh    <= o_10[31:0];
      out_q.cov_vv    <= o_11[31:0];
      out_q.saturated <= clip_q | o_h[32] | o_v[32] | o_00[32] | o_01[32] |
                         o_10[32] | o_11[32];
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ===== rtl/akf_checker.sv =====
// port checker of the altitude kalman filter and its bind
`default_nettype none
module akf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input akf_pkg::out_item_t out_data_o
);

  // an accepted transaction keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

  // covariance stays symmetric
  a_cov_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.cov_hv == out_data_o.cov_vh))
    else $error("covariance off-diagonal words differ");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

endmodule

bind altitude_kalman_filter_2state akf_checker u_akf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

// ===== dv/altitude_kalman_filter_2state_tb.sv =====
// self-checking testbench of the two-state altitude kalman filter
`timescale 1ns / 1ps
module altitude_kalman_filter_2state_tb;
  import akf_pkg::*;

  localparam longint TermLimit = 64'sd1 << 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  altitude_kalman_filter_2state DUT (.*);

  always #5 clk_i = ~clk_i;

  // filter state mirror
  logic [30:0] gravity_q, accel_var_q, sonar_var_q, sonar_off_q;
  longint height_q, velocity_q;
  longint cov_q [4];
  bit clipped;

  in_item_t pending_q[$];
  out_item_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint clamp_term(bit neg, logic [127:0] m);
    logic [127:0] v;
    v = m;
    if (v > 128'(TermLimit)) begin
      v = 128'(TermLimit);
      clipped = 1;
    end
    return neg ? -longint'(v[63:0]) : longint'(v[63:0]);
  endfunction

  function automatic longint round_shift(longint a, longint unsigned b, int sh);
    logic [127:0] p;
    p = 128'(a < 0 ? -a : a) * 128'(b);
    p = (p + (128'd1 << (sh - 1))) >> sh;
    return clamp_term(a < 0, p);
  endfunction

  function automatic longint round_div(longint a, longint b, longint d);
    logic [127:0] p;
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b) + 128'(d >>> 1);
    p = p / 128'(d);
    return clamp_term((a < 0) != (b < 0), p);
  endfunction

  function automatic longint sat_word(longint x);
    if (x > 64'sd2147483647) begin
      clipped = 1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      clipped = 1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void filter_reset();
    gravity_q = GravityRst;
    accel_var_q = AccelVarRst;
    sonar_var_q = SonarVarRst;
    sonar_off_q = SonarOffsetRst;
    height_q = 0;
    velocity_q = 0;
    cov_q = '{41943, 0, 0, 41943};
  endfunction

  function automatic out_item_t filter_step(in_item_t it);
    longint p00, p01, p10, p11, h, v, acc, q, s, y;
    longint unsigned mx, my, mz, dt, dt2, dt3, dt4;
    out_item_t r;
    clipped = 0;
    p00 = cov_q[0]; p01 = cov_q[1]; p10 = cov_q[2]; p11 = cov_q[3];
    h = height_q; v = velocity_q;
    if (!it.cmd) begin
      mx = 64'(it.accel_x < 0 ? -longint'(it.accel_x) : longint'(it.accel_x));
      my = 64'(it.accel_y < 0 ? -longint'(it.accel_y) : longint'(it.accel_y));
      mz = 64'(it.accel_z < 0 ? -longint'(it.accel_z) : longint'(it.accel_z));
      acc = longint'(root64(mx * mx + my * my + mz * mz)) - longint'(gravity_q);
      dt = it.dt; dt2 = dt * dt; dt3 = dt2 * dt; dt4 = dt2 * dt2;
      q = longint'(accel_var_q);
      height_q = sat_word(h + round_shift(v, dt, 16) + round_shift(acc, dt2, 33));
      velocity_q = sat_word(v + round_shift(acc, dt, 16));
      cov_q[0] = sat_word(p00 + round_shift(p01 + p10, dt, 16)
                          + round_shift(p11, dt2, 32) + round_shift(q, dt4, 66));
      cov_q[1] = sat_word(p01 + round_shift(p11, dt, 16) + round_shift(q, dt3, 49));
      cov_q[2] = sat_word(p10 + round_shift(p11, dt, 16) + round_shift(q, dt3, 49));
      cov_q[3] = sat_word(p11 + round_shift(q, dt2, 32));
    end else begin
      s = p00 + longint'(sonar_var_q);
      y = longint'(it.range_m) - longint'(sonar_off_q) - h;
      if (s <= 0) begin
        clipped = 1;
      end else begin
        height_q = sat_word(h + round_div(p00, y, s));
        velocity_q = sat_word(v + round_div(p10, y, s));
        cov_q[0] = sat_word(p00 - round_div(p00, p00, s));
        cov_q[1] = sat_word(p01 - round_div(p00, p01, s));
        cov_q[2] = sat_word(p10 - round_div(p10, p00, s));
        cov_q[3] = sat_word(p11 - round_div(p10, p01, s));
      end
    end
    r.height = 32'(sat_word(height_q));
    r.velocity = 32'(sat_word(velocity_q));
    r.cov_hh = 32'(sat_word(cov_q[0]));
    r.cov_hv = 32'(sat_word(cov_q[1]));
    r.cov_vh = 32'(sat_word(cov_q[2]));
    r.cov_vv = 32'(sat_word(cov_q[3]));
    r.saturated = clipped;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_q.push_back(filter_step(in_data_i));
    end
    if (!in_valid_i || !in_stall_o) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i <= pending_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t e, a;
    if (out_valid_o && !out_stall_i) begin
      a = out_data_o;
      if (expected_q.size() == 0) begin
        $error("unexpected transaction %p", a);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (a.height !== e.height) begin
          $error("height exp %0d got %0d", e.height, a.height); errors++;
        end
        if (a.velocity !== e.velocity) begin
          $error("velocity exp %0d got %0d", e.velocity, a.velocity); errors++;
        end
        if (a.cov_hh !== e.cov_hh) begin
          $error("cov_hh exp %0d got %0d", e.cov_hh, a.cov_hh); errors++;
        end
        if (a.cov_hv !== e.cov_hv) begin
          $error("cov_hv exp %0d got %0d", e.cov_hv, a.cov_hv); errors++;
        end
        if (a.cov_vh !== e.cov_vh) begin
          $error("cov_vh exp %0d got %0d", e.cov_vh, a.cov_vh); errors++;
        end
        if (a.cov_vv !== e.cov_vv) begin
          $error("cov_vv exp %0d got %0d", e.cov_vv, a.cov_vv); errors++;
        end
        if (a.saturated !== e.saturated) begin
          $error("saturated exp %0d got %0d", e.saturated, a.saturated); errors++;
        end
      end
    end
  end

  // sampled at the falling edge so the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_GRAVITY:      gravity_q = val[30:0];
      REG_ACCEL_VAR:    accel_var_q = val[30:0];
      REG_SONAR_VAR:    sonar_var_q = val[30:0];
      REG_SONAR_OFFSET: sonar_off_q = val[30:0];
      default: ;
    endcase
  endtask

  function automatic in_item_t make_predict(logic [15:0] dt, logic [31:0] ax,
                                            logic [31:0] ay, logic [31:0] az);
    in_item_t it;
    it = '0;
    it.cmd = 1'b0;
    it.dt = dt;
    it.accel_x = ax;
    it.accel_y = ay;
    it.accel_z = az;
    it.range_m = 31'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_measure(logic [30:0] rng);
    in_item_t it;
    it = make_predict(16'($urandom), $urandom, $urandom, $urandom);
    it.cmd = 1'b1;
    it.range_m = rng;
    return it;
  endfunction

  function automatic logic [31:0] rand_accel();
    case ($urandom_range(3))
      0: return $urandom;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0) begin
        pending_q.push_back(make_measure($urandom_range(3) == 0 ? 31'($urandom)
                                         : 31'($urandom_range(2000000))));
      end else begin
        pending_q.push_back(make_predict($urandom_range(4) == 0 ? 16'($urandom)
                                         : 16'($urandom_range(1500)),
                                         rand_accel(), rand_accel(), rand_accel()));
      end
    end
    wait_drained();
  endtask

  initial begin
    filter_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    pending_q.push_back(make_predict(16'd655, 32'd0, 32'd0, 32'd642253));
    pending_q.push_back(make_measure(31'd70000));
    pending_q.push_back(make_measure(31'd0));
    pending_q.push_back(make_predict(16'hffff, 32'h7fffffff, 32'h80000000, 32'h80000000));
    pending_q.push_back(make_predict(16'd0, 32'hffffffff, 32'd1, 32'd0));
    pending_q.push_back(make_measure(31'h7fffffff));
    pending_q.push_back(make_predict(16'hffff, 32'h80000000, 32'h80000000, 32'h80000000));
    pending_q.push_back(make_predict(16'hffff, 32'h80000000, 32'h80000000, 32'h80000000));
    pending_q.push_back(make_measure(31'd1));
    pending_q.push_back(make_measure(31'h55555555));
    pending_q.push_back(make_measure(31'h2aaaaaaa));
    wait_drained();

    // drive covariance negative for the non-positive innovation case
    write_reg(REG_SONAR_VAR, 32'd1);
    write_reg(REG_ACCEL_VAR, 32'h7fffffff);
    write_reg(REG_GRAVITY, 32'd0);
    write_reg(REG_SONAR_OFFSET, 32'h7fffffff);
    pending_q.push_back(make_measure(31'd5));
    pending_q.push_back(make_predict(16'hffff, $urandom, $urandom, $urandom));
    pending_q.push_back(make_measure(31'd100));
    pending_q.push_back(make_measure(31'h7fffffff));
    wait_drained();

    random_phase(60, 0, 0);
    write_reg(REG_GRAVITY, 32'h7fffffff);
    write_reg(REG_ACCEL_VAR, 32'd0);
    write_reg(REG_SONAR_VAR, 32'h7fffffff);
    write_reg(REG_SONAR_OFFSET, 32'd0);
    random_phase(60, 46, 0);
    write_reg(REG_GRAVITY, 32'd642253);
    write_reg(REG_ACCEL_VAR, 32'd132540);
    write_reg(REG_SONAR_VAR, 32'd1678);
    write_reg(REG_SONAR_OFFSET, 32'd2556);
    random_phase(200, 0, 46);
    write_reg(REG_GRAVITY, $urandom_range(1000000));
    write_reg(REG_ACCEL_VAR, $urandom_range(10000000));
    write_reg(REG_SONAR_VAR, $urandom_range(1000000) + 1);
    write_reg(REG_SONAR_OFFSET, $urandom_range(100000));
    random_phase(200, 26, 26);
    random_phase(110, 0, 0);

    if (errors == 0) begin
      $display("altitude_kalman_filter_2state_tb OK");
    end else begin
      $display("altitude_kalman_filter_2state_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("altitude_kalman_filter_2state_tb NOT OK");
    $finish;
  end

endmodule
